// ----- sv/psu_pkg.sv -----
package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 8192;
  localparam int MAX_PIXEL_BYTES_DEF = 8;

  localparam int ROW_BYTES_W = 14;
  localparam int BPP_W       = 4;
  localparam int ROW_COUNT_W = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_BYTES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BPP       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 2'd2;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [7:0] FILT_TYPE_MAX = 8'd4;

  localparam logic [1:0] KIND_DROP = 2'd0;
  localparam logic [1:0] KIND_FILT = 2'd1;
  localparam logic [1:0] KIND_PIX  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0]         res;
    pa = 11'(signed'({3'b000, b})) - 11'(signed'({3'b000, c}));
    pb = 11'(signed'({3'b000, a})) - 11'(signed'({3'b000, c}));
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ----- sv/png_scanline_unfilter_core.sv -----
// A pixel beat is registered in the compute stage (s1) and then in the output register
// before it is shown on the master side. One byte per cycle unless m_tready stalls the
// output; the line store reads at accept and writes as s1 advances; rows need no gap.
// Reset (rst, synchronous, active high) clears the pipeline, the error halt and the
// row and image counters; registers return to 4 bytes per row, 4 bytes per pixel, 1 row.
// The line store is not cleared; the first row of each image ignores what it reads.
module png_scanline_unfilter_core
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] data_byte
  input  logic                  s_tuser,    // [0] frame_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,    // [7:0] pixel_byte
  output logic                  m_tlast,    // last_of_image
  output logic [1:0]            m_tuser,    // [0] last_of_row, [1] bad_filter
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  typedef struct packed {
    logic [1:0]    kind;
    logic [7:0]    data;
    logic [2:0]    mode;
    logic          first_row;
    logic [AW-1:0] addr;
    logic          end_row;
    logic          end_image;
  } s1_t;

  logic [ROW_BYTES_W-1:0] row_bytes;
  logic [BPP_W-1:0]       bytes_per_pixel;
  logic [ROW_COUNT_W-1:0] row_count;

  logic [PW-1:0]          byte_pos;
  logic [ROW_COUNT_W-1:0] row_index;
  logic                   first_row;
  logic                   halted;
  logic [2:0]             filter_mode;

  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] above_rd;
  logic [7:0] left_hist  [MAX_PIXEL_BYTES];
  logic [7:0] above_hist [MAX_PIXEL_BYTES];

  s1_t  s1;
  s1_t  s1_next;
  logic s1_valid;
  logic s1_adv;
  logic s_accept;

  logic [7:0] out_byte;
  logic       out_last_row;
  logic       out_last_image;
  logic       out_bad;
  logic       out_valid;

  logic [31:0]            rb_ext;
  logic [31:0]            bpp_ext;
  logic [PW-1:0]          eff_rb;
  logic [HW-1:0]          hist_idx;
  logic [ROW_COUNT_W:0]   eff_rc;
  logic [PW-1:0]          cur_pos;
  logic [ROW_COUNT_W-1:0] cur_row;
  logic                   cur_first;
  logic                   cur_halted;
  logic [ROW_COUNT_W:0]   row_inc;

  logic [PW-1:0]          byte_pos_next;
  logic [ROW_COUNT_W-1:0] row_index_next;
  logic                   first_row_next;
  logic                   halted_next;
  logic [2:0]             filter_mode_next;

  logic [7:0] nb_a;
  logic [7:0] nb_b;
  logic [7:0] nb_c;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] val;

  always_comb begin
    rb_ext  = 32'(row_bytes);
    bpp_ext = 32'(bytes_per_pixel);
    if (rb_ext == 32'd0) begin
      eff_rb = PW'(1);
    end else if (rb_ext > 32'(MAX_ROW_BYTES)) begin
      eff_rb = PW'(MAX_ROW_BYTES);
    end else begin
      eff_rb = PW'(rb_ext);
    end
    if (bpp_ext == 32'd0) begin
      hist_idx = '0;
    end else if (bpp_ext > 32'(MAX_PIXEL_BYTES)) begin
      hist_idx = HW'(MAX_PIXEL_BYTES - 1);
    end else begin
      hist_idx = HW'(bpp_ext - 32'd1);
    end
    eff_rc = (row_count == '0) ? (ROW_COUNT_W+1)'(1) : {1'b0, row_count};
  end

  assign s1_adv   = s1_valid && (!out_valid || m_tready || s1.kind == KIND_FILT);
  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    cur_pos    = s_tuser ? '0 : byte_pos;
    cur_row    = s_tuser ? '0 : row_index;
    cur_first  = s_tuser ? 1'b1 : first_row;
    cur_halted = s_tuser ? 1'b0 : halted;
    row_inc    = {1'b0, cur_row} + (ROW_COUNT_W+1)'(1);

    byte_pos_next    = cur_pos;
    row_index_next   = cur_row;
    first_row_next   = cur_first;
    halted_next      = cur_halted;
    filter_mode_next = filter_mode;

    s1_next           = '0;
    s1_next.kind      = KIND_DROP;
    s1_next.data      = s_tdata;
    s1_next.mode      = filter_mode;
    s1_next.first_row = cur_first;
    s1_next.addr      = AW'(PW'(cur_pos - PW'(1)));

    if (cur_halted) begin
      s1_next.kind = KIND_DROP;
    end else if (cur_pos == '0) begin
      if (s_tdata > FILT_TYPE_MAX) begin
        s1_next.kind = KIND_ERR;
        halted_next  = 1'b1;
      end else begin
        s1_next.kind     = KIND_FILT;
        filter_mode_next = s_tdata[2:0];
        byte_pos_next    = PW'(1);
      end
    end else begin
      s1_next.kind = KIND_PIX;
      if (cur_pos >= eff_rb) begin
        s1_next.end_row = 1'b1;
        byte_pos_next   = '0;
        if (row_inc >= eff_rc) begin
          s1_next.end_image = 1'b1;
          row_index_next    = '0;
          first_row_next    = 1'b1;
        end else begin
          row_index_next = ROW_COUNT_W'(row_inc);
          first_row_next = 1'b0;
        end
      end else begin
        byte_pos_next = PW'(cur_pos + PW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes       <= ROW_BYTES_W'(4);
      bytes_per_pixel <= BPP_W'(4);
      row_count       <= ROW_COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_BYTES: row_bytes       <= cfg_wdata[ROW_BYTES_W-1:0];
        REG_BPP:       bytes_per_pixel <= cfg_wdata[BPP_W-1:0];
        REG_ROW_COUNT: row_count       <= cfg_wdata[ROW_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      row_index   <= '0;
      first_row   <= 1'b1;
      halted      <= 1'b0;
      filter_mode <= FILT_NONE;
    end else if (s_accept) begin
      byte_pos    <= byte_pos_next;
      row_index   <= row_index_next;
      first_row   <= first_row_next;
      halted      <= halted_next;
      filter_mode <= filter_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= (s1_next.kind != KIND_DROP);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1       <= s1_next;
      above_rd <= line_mem[s1_next.addr];
    end
  end

  always_comb begin
    nb_a    = left_hist[hist_idx];
    nb_b    = s1.first_row ? 8'd0 : above_rd;
    nb_c    = s1.first_row ? 8'd0 : above_hist[hist_idx];
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (s1.mode)
      FILT_SUB:   pred = nb_a;
      FILT_UP:    pred = nb_b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth_pred(nb_a, nb_b, nb_c);
      default:    pred = 8'd0;
    endcase
    val = s1.data + pred;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.kind == KIND_PIX) begin
      line_mem[s1.addr] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k]  <= 8'd0;
        above_hist[k] <= 8'd0;
      end
    end else if (s1_adv && s1.kind == KIND_FILT) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k]  <= 8'd0;
        above_hist[k] <= 8'd0;
      end
    end else if (s1_adv && s1.kind == KIND_PIX) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist[k]  <= left_hist[k-1];
        above_hist[k] <= above_hist[k-1];
      end
      left_hist[0]  <= val;
      above_hist[0] <= nb_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && (s1.kind inside {KIND_PIX, KIND_ERR})) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.kind == KIND_PIX) begin
      out_byte       <= val;
      out_last_row   <= s1.end_row;
      out_last_image <= s1.end_image;
      out_bad        <= 1'b0;
    end else if (s1_adv && s1.kind == KIND_ERR) begin
      out_byte       <= 8'd0;
      out_last_row   <= 1'b0;
      out_last_image <= 1'b0;
      out_bad        <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last_image;
  assign m_tuser  = {out_bad, out_last_row};

  a_image_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("Image end without row end.");

  a_error_beat_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 8'd0 && !m_tlast && !m_tuser[0])
    else $error("Error beat carries pixel data or end flags.");

  a_stalled_stage_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> !s_tready)
    else $error("Input taken while the compute stage is stalled.");

  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    halted && s_accept && !s_tuser |=> halted && !s1_valid)
    else $error("Halt released without frame start.");

endmodule
